// File: hdl/sfkh_pkg.sv
// Package for the symmetric flow key hash: the beat and pipeline types, the key constants
// and the lookup3 mixing steps.
// It depends on nothing else. Every module of the block imports it.
package sfkh_pkg;

    typedef logic [31:0] word_t;

    // Kind codes carried on the func field.
    localparam logic [2:0] FUNC_IPV4_PORTS = 3'd0;
    localparam logic [2:0] FUNC_IPV4_OTHER = 3'd1;
    localparam logic [2:0] FUNC_IPV6       = 3'd2;
    localparam logic [2:0] FUNC_ZIGBEE     = 3'd3;

    // Fixed port pair for IPv4 packets without ports.
    localparam logic [15:0] FIXED_SP = 16'hfeed;
    localparam logic [15:0] FIXED_DP = 16'hbeef;

    // Key lengths in 32-bit words.
    localparam logic [3:0] WORDS_IPV4   = 4'd5;
    localparam logic [3:0] WORDS_IPV6   = 4'd11;
    localparam logic [3:0] WORDS_ZIGBEE = 4'd2;

    // Constant that lookup3 adds to the initial state.
    localparam word_t HASH_INIT = 32'hdeadbeef;

    // Number of full mixing rounds that the longest key needs.
    localparam int ROUNDS = 3;

    // One input beat as it arrives on the ports.
    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  proto;
        logic [7:0]  tunnel_depth;
        logic [15:0] vlan_outer;
        logic [15:0] vlan_inner;
    } in_t;

    // Outcome of the ordering compares.
    typedef struct packed {
        logic v4_src_gt;
        logic v6_src_gt;
        logic port_src_gt;
    } cmp_t;

    // Internal state of the hash.
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
    } abc_t;

    // Payload that travels down the hash pipeline. The mixing words are consumed
    // three at a time from the bottom; round_en[0] says whether the next round applies.
    typedef struct packed {
        logic                         zero;
        logic [ROUNDS-1:0]            round_en;
        logic [3*ROUNDS-1:0][31:0]    mix_words;
        logic [1:0][31:0]             tail_words;
        abc_t                         st;
    } hp_t;

    function automatic word_t rotl(input word_t x, input int unsigned k);
        return (x << k) | (x >> (32 - k));
    endfunction

    // First half of the lookup3 mix: add three key words, then three steps.
    function automatic abc_t mix_first(input abc_t s, input word_t k0, input word_t k1,
                                       input word_t k2);
        word_t a;
        word_t b;
        word_t c;
        a = s.a + k0;
        b = s.b + k1;
        c = s.c + k2;
        a = a - c; a = a ^ rotl(c, 4);  c = c + b;
        b = b - a; b = b ^ rotl(a, 6);  a = a + c;
        c = c - b; c = c ^ rotl(b, 8);  b = b + a;
        return '{a: a, b: b, c: c};
    endfunction

    // Second half of the lookup3 mix.
    function automatic abc_t mix_second(input abc_t s);
        word_t a;
        word_t b;
        word_t c;
        a = s.a;
        b = s.b;
        c = s.c;
        a = a - c; a = a ^ rotl(c, 16); c = c + b;
        b = b - a; b = b ^ rotl(a, 19); a = a + c;
        c = c - b; c = c ^ rotl(b, 4);  b = b + a;
        return '{a: a, b: b, c: c};
    endfunction

    // First half of the lookup3 final: add the last two words, then four steps.
    function automatic abc_t final_first(input abc_t s, input word_t t0, input word_t t1);
        word_t a;
        word_t b;
        word_t c;
        a = s.a + t0;
        b = s.b + t1;
        c = s.c;
        c = c ^ b; c = c - rotl(b, 14);
        a = a ^ c; a = a - rotl(c, 11);
        b = b ^ a; b = b - rotl(a, 25);
        c = c ^ b; c = c - rotl(b, 16);
        return '{a: a, b: b, c: c};
    endfunction

    // Second half of the lookup3 final; the hash is the c word of the result.
    function automatic abc_t final_second(input abc_t s);
        word_t a;
        word_t b;
        word_t c;
        a = s.a;
        b = s.b;
        c = s.c;
        a = a ^ c; a = a - rotl(c, 4);
        b = b ^ a; b = b - rotl(a, 14);
        c = c ^ b; c = c - rotl(b, 24);
        return '{a: a, b: b, c: c};
    endfunction

endpackage

// File: hdl/symmetric_flow_key_hash.sv
// Symmetric flow key hash: one 32-bit lookup3 hash per packet header, direction-free.
// done and key_hash come from the final's result register; the front end has three
// stages, each of the three mixing rounds two, and the final two.
// Throughput: one beat per cycle, busy is always low and the receiver cannot stall.
// Reset clears the valid bits of every stage and sets hash_seed to zero.
// Depends on sfkh_pkg, sfkh_norm, sfkh_mix and sfkh_final.
module symmetric_flow_key_hash
    import sfkh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [63:0] src_hi,
    input  logic [63:0] src_lo,
    input  logic [63:0] dst_hi,
    input  logic [63:0] dst_lo,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [7:0]  proto,
    input  logic [7:0]  tunnel_depth,
    input  logic [15:0] vlan_outer,
    input  logic [15:0] vlan_inner,
    input  logic        hash_seed_we,
    input  logic [31:0] hash_seed_wdata,
    output logic        done,
    output logic [31:0] key_hash
);

    word_t hash_seed_reg;
    in_t   in_item;
    logic  valid_q [ROUNDS+1];
    hp_t   hp_q    [ROUNDS+1];

    // Seed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg <= '0;
        end
        else if (hash_seed_we)
        begin
            hash_seed_reg <= hash_seed_wdata;
        end
    end

    assign busy = 1'b0;

    assign in_item = '{func: func, src_hi: src_hi, src_lo: src_lo, dst_hi: dst_hi,
                       dst_lo: dst_lo, src_port: src_port, dst_port: dst_port,
                       proto: proto, tunnel_depth: tunnel_depth,
                       vlan_outer: vlan_outer, vlan_inner: vlan_inner};

    sfkh_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_item   (in_item),
        .seed      (hash_seed_reg),
        .out_valid (valid_q[0]),
        .out_hp    (hp_q[0])
    );

    // Chain of mixing rounds.
    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        sfkh_mix u_mix (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_q[r]),
            .in_hp     (hp_q[r]),
            .out_valid (valid_q[r+1]),
            .out_hp    (hp_q[r+1])
        );
    end

    sfkh_final u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_q[ROUNDS]),
        .in_hp     (hp_q[ROUNDS]),
        .done      (done),
        .key_hash  (key_hash)
    );

endmodule

// File: hdl/sfkh_norm.sv
// Front end of the flow hash: captures a beat, orders addresses and ports, and lays out
// the key words and the initial hash state. Three register stages.
// Depends on sfkh_pkg.
module sfkh_norm
    import sfkh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  in_t   in_item,
    input  word_t seed,
    output logic  out_valid,
    output hp_t   out_hp
);

    logic s1_valid_reg;
    in_t  s1_item_reg;
    logic s2_valid_reg;
    in_t  s2_item_reg;
    cmp_t s2_cmp_reg;
    cmp_t s2_cmp_next;
    logic s3_valid_reg;
    hp_t  s3_hp_reg;
    hp_t  s3_hp_next;

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Ordering compares on the captured beat.
    always_comb
    begin
        s2_cmp_next.v4_src_gt   = s1_item_reg.src_lo[31:0] > s1_item_reg.dst_lo[31:0];
        s2_cmp_next.v6_src_gt   = (s1_item_reg.src_hi > s1_item_reg.dst_hi) ||
                                  ((s1_item_reg.src_hi == s1_item_reg.dst_hi) &&
                                   (s1_item_reg.src_lo > s1_item_reg.dst_lo));
        s2_cmp_next.port_src_gt = s1_item_reg.src_port > s1_item_reg.dst_port;
    end

    // Key layout and initial state. IPv4 words sit in the last mixing round, so that the
    // earlier rounds pass them by; ZigBee goes straight to the final.
    always_comb
    begin
        logic [63:0] a_hi;
        logic [63:0] a_lo;
        logic [63:0] b_hi;
        logic [63:0] b_lo;
        word_t       a4;
        word_t       b4;
        logic [15:0] pmax;
        logic [15:0] pmin;
        word_t       port_w;
        word_t       proto_w;
        word_t       vlan_w;
        logic [3:0]  len;

        a_hi    = s2_cmp_reg.v6_src_gt ? s2_item_reg.src_hi : s2_item_reg.dst_hi;
        a_lo    = s2_cmp_reg.v6_src_gt ? s2_item_reg.src_lo : s2_item_reg.dst_lo;
        b_hi    = s2_cmp_reg.v6_src_gt ? s2_item_reg.dst_hi : s2_item_reg.src_hi;
        b_lo    = s2_cmp_reg.v6_src_gt ? s2_item_reg.dst_lo : s2_item_reg.src_lo;
        a4      = s2_cmp_reg.v4_src_gt ? s2_item_reg.src_lo[31:0] : s2_item_reg.dst_lo[31:0];
        b4      = s2_cmp_reg.v4_src_gt ? s2_item_reg.dst_lo[31:0] : s2_item_reg.src_lo[31:0];
        pmax    = s2_cmp_reg.port_src_gt ? s2_item_reg.src_port : s2_item_reg.dst_port;
        pmin    = s2_cmp_reg.port_src_gt ? s2_item_reg.dst_port : s2_item_reg.src_port;
        port_w  = {pmin, pmax};
        proto_w = {8'd0, s2_item_reg.tunnel_depth, 8'd0, s2_item_reg.proto};
        vlan_w  = {s2_item_reg.vlan_inner, s2_item_reg.vlan_outer};
        len     = WORDS_ZIGBEE;

        s3_hp_next            = '0;
        s3_hp_next.zero       = 1'b0;
        case (s2_item_reg.func) inside
            FUNC_IPV4_PORTS, FUNC_IPV4_OTHER:
            begin
                len                        = WORDS_IPV4;
                s3_hp_next.round_en        = 3'b100;
                s3_hp_next.mix_words[6]    = a4;
                s3_hp_next.mix_words[7]    = b4;
                s3_hp_next.mix_words[8]    = (s2_item_reg.func == FUNC_IPV4_PORTS) ?
                                             port_w : {FIXED_DP, FIXED_SP};
                s3_hp_next.tail_words[0]   = proto_w;
                s3_hp_next.tail_words[1]   = vlan_w;
            end
            FUNC_IPV6:
            begin
                len                        = WORDS_IPV6;
                s3_hp_next.round_en        = 3'b111;
                s3_hp_next.mix_words[0]    = a_hi[63:32];
                s3_hp_next.mix_words[1]    = a_hi[31:0];
                s3_hp_next.mix_words[2]    = a_lo[63:32];
                s3_hp_next.mix_words[3]    = a_lo[31:0];
                s3_hp_next.mix_words[4]    = b_hi[63:32];
                s3_hp_next.mix_words[5]    = b_hi[31:0];
                s3_hp_next.mix_words[6]    = b_lo[63:32];
                s3_hp_next.mix_words[7]    = b_lo[31:0];
                s3_hp_next.mix_words[8]    = port_w;
                s3_hp_next.tail_words[0]   = proto_w;
                s3_hp_next.tail_words[1]   = vlan_w;
            end
            FUNC_ZIGBEE:
            begin
                len                        = WORDS_ZIGBEE;
                s3_hp_next.round_en        = 3'b000;
                s3_hp_next.tail_words[0]   = {pmax, s2_item_reg.vlan_outer};
                s3_hp_next.tail_words[1]   = {s2_item_reg.vlan_inner, pmin};
            end
            default:
            begin
                // Unknown kind: the hash is forced to zero at the end.
                s3_hp_next.zero            = 1'b1;
                s3_hp_next.round_en        = 3'b000;
            end
        endcase

        s3_hp_next.st.a = HASH_INIT + {26'd0, len, 2'b00} + seed;
        s3_hp_next.st.b = s3_hp_next.st.a;
        s3_hp_next.st.c = s3_hp_next.st.a;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_item_reg <= in_item;
        s2_item_reg <= s1_item_reg;
        s2_cmp_reg  <= s2_cmp_next;
        s3_hp_reg   <= s3_hp_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_hp    = s3_hp_reg;

endmodule

// File: hdl/sfkh_mix.sv
// One lookup3 mixing round over two register stages, applied only when the round is
// enabled for the beat. Consumes the lowest three key words.
// Depends on sfkh_pkg.
module sfkh_mix
    import sfkh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  hp_t  in_hp,
    output logic out_valid,
    output hp_t  out_hp
);

    logic h1_valid_reg;
    hp_t  h1_hp_reg;
    hp_t  h1_hp_next;
    logic h2_valid_reg;
    hp_t  h2_hp_reg;
    hp_t  h2_hp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_valid_reg <= 1'b0;
            h2_valid_reg <= 1'b0;
        end
        else
        begin
            h1_valid_reg <= in_valid;
            h2_valid_reg <= h1_valid_reg;
        end
    end

    // First half: key word additions and three steps.
    always_comb
    begin
        h1_hp_next = in_hp;
        if (in_hp.round_en[0])
        begin
            h1_hp_next.st = mix_first(in_hp.st, in_hp.mix_words[0], in_hp.mix_words[1],
                                      in_hp.mix_words[2]);
        end
    end

    // Second half, then move the next round's words and enable to the bottom.
    always_comb
    begin
        h2_hp_next           = h1_hp_reg;
        h2_hp_next.mix_words = h1_hp_reg.mix_words >> 96;
        h2_hp_next.round_en  = {1'b0, h1_hp_reg.round_en[ROUNDS-1:1]};
        if (h1_hp_reg.round_en[0])
        begin
            h2_hp_next.st = mix_second(h1_hp_reg.st);
        end
    end

    always_ff @(posedge clk)
    begin
        h1_hp_reg <= h1_hp_next;
        h2_hp_reg <= h2_hp_next;
    end

    assign out_valid = h2_valid_reg;
    assign out_hp    = h2_hp_reg;

endmodule

// File: hdl/sfkh_final.sv
// lookup3 final over two register stages; the second stage is the result register that
// drives the strobe and the hash.
// Depends on sfkh_pkg.
module sfkh_final
    import sfkh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  hp_t   in_hp,
    output logic  done,
    output word_t key_hash
);

    logic  f1_valid_reg;
    logic  f1_zero_reg;
    abc_t  f1_st_reg;
    abc_t  f1_st_next;
    logic  done_reg;
    word_t hash_reg;
    word_t hash_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= in_valid;
            done_reg     <= f1_valid_reg;
        end
    end

    // Tail words go in here; the remainder is always two words for the known kinds.
    assign f1_st_next = final_first(in_hp.st, in_hp.tail_words[0], in_hp.tail_words[1]);

    always_comb
    begin
        abc_t fin;
        fin       = final_second(f1_st_reg);
        hash_next = f1_zero_reg ? '0 : fin.c;
    end

    always_ff @(posedge clk)
    begin
        f1_st_reg   <= f1_st_next;
        f1_zero_reg <= in_hp.zero;
        hash_reg    <= hash_next;
    end

    assign done     = done_reg;
    assign key_hash = hash_reg;

endmodule

// File: hdl/sfkh_checker.sv
// Port-level checker for the symmetric flow key hash, with the bind that attaches it.
// It sees only the top level's ports and takes the kind codes from sfkh_pkg.
module sfkh_checker
    import sfkh_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  func,
    input logic [63:0] src_hi,
    input logic [63:0] src_lo,
    input logic [63:0] dst_hi,
    input logic [63:0] dst_lo,
    input logic [15:0] src_port,
    input logic [15:0] dst_port,
    input logic [7:0]  proto,
    input logic [7:0]  tunnel_depth,
    input logic [15:0] vlan_outer,
    input logic [15:0] vlan_inner,
    input logic        done,
    input logic [31:0] key_hash
);

    localparam int         LAT    = 11;
    localparam logic [3:0] SETTLE = 4'd12;

    logic [3:0] settle_reg;

    // Cycles since reset, so that history from before reset is not compared.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= '0;
        end
        else if (settle_reg != SETTLE)
        begin
            settle_reg <= settle_reg + 4'd1;
        end
    end

    // The block never refuses a beat.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every accepted beat gives exactly one result a fixed time later.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (settle_reg == SETTLE) |-> (done == $past(start, LAT)))
        else $error("result strobe does not match accepted beats");

    // Unknown kinds hash to zero.
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((settle_reg == SETTLE) && done && ($past(func, LAT) > FUNC_ZIGBEE)) |->
        (key_hash == '0))
        else $error("unknown kind gave a nonzero hash");

    // Two back-to-back beats that differ only by direction give the same hash.
    a_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        ((settle_reg == SETTLE) && done && $past(done) &&
         ($past(func, LAT) == $past(func, LAT + 1)) &&
         ($past(src_hi, LAT) == $past(dst_hi, LAT + 1)) &&
         ($past(src_lo, LAT) == $past(dst_lo, LAT + 1)) &&
         ($past(dst_hi, LAT) == $past(src_hi, LAT + 1)) &&
         ($past(dst_lo, LAT) == $past(src_lo, LAT + 1)) &&
         ($past(src_port, LAT) == $past(dst_port, LAT + 1)) &&
         ($past(dst_port, LAT) == $past(src_port, LAT + 1)) &&
         ($past(proto, LAT) == $past(proto, LAT + 1)) &&
         ($past(tunnel_depth, LAT) == $past(tunnel_depth, LAT + 1)) &&
         ($past(vlan_outer, LAT) == $past(vlan_outer, LAT + 1)) &&
         ($past(vlan_inner, LAT) == $past(vlan_inner, LAT + 1)))
        |-> (key_hash == $past(key_hash)))
        else $error("hash depends on direction");

endmodule

bind symmetric_flow_key_hash sfkh_checker u_sfkh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .src_hi       (src_hi),
    .src_lo       (src_lo),
    .dst_hi       (dst_hi),
    .dst_lo       (dst_lo),
    .src_port     (src_port),
    .dst_port     (dst_port),
    .proto        (proto),
    .tunnel_depth (tunnel_depth),
    .vlan_outer   (vlan_outer),
    .vlan_inner   (vlan_inner),
    .done         (done),
    .key_hash     (key_hash)
);

// File: tb/sfkh_hash_checker.sv
// Checker for the symmetric flow key hash: keeps its own lookup3 predictor and seed copy,
// queues one expected hash per accepted beat and compares each done strobe with the oldest.
// Depends on sfkh_pkg for the beat type, the kind codes and the key constants.
`timescale 1ns / 1ps

module sfkh_hash_checker
    import sfkh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_t         beat,
    input  logic        hash_seed_we,
    input  logic [31:0] hash_seed_wdata,
    input  logic        done,
    input  logic [31:0] key_hash,
    output int          outstanding,
    output int          mismatches
);

    word_t seed_copy;
    word_t expected_hashes[$];
    word_t oldest;

    function automatic word_t rot32(input word_t x, input int unsigned k);
        return (x << k) | (x >> (32 - k));
    endfunction

    // Word-oriented lookup3 over the first n words of the key.
    function automatic word_t lookup3_hash(input word_t key[11], input int unsigned n,
                                           input word_t seed);
        word_t a;
        word_t b;
        word_t c;
        int unsigned pos;
        int unsigned left;
        a = HASH_INIT + word_t'(n << 2) + seed;
        b = a;
        c = a;
        pos = 0;
        left = n;
        while (left > 3)
        begin
            a += key[pos];
            b += key[pos + 1];
            c += key[pos + 2];
            a -= c; a ^= rot32(c, 4);  c += b;
            b -= a; b ^= rot32(a, 6);  a += c;
            c -= b; c ^= rot32(b, 8);  b += a;
            a -= c; a ^= rot32(c, 16); c += b;
            b -= a; b ^= rot32(a, 19); a += c;
            c -= b; c ^= rot32(b, 4);  b += a;
            left -= 3;
            pos += 3;
        end
        if (left == 0)
            return c;
        if (left == 3)
            c += key[pos + 2];
        if (left >= 2)
            b += key[pos + 1];
        a += key[pos];
        c ^= b; c -= rot32(b, 14);
        a ^= c; a -= rot32(c, 11);
        b ^= a; b -= rot32(a, 25);
        c ^= b; c -= rot32(b, 16);
        a ^= c; a -= rot32(c, 4);
        b ^= a; b -= rot32(a, 14);
        c ^= b; c -= rot32(b, 24);
        return c;
    endfunction

    // Builds the direction-free key for one beat and hashes it.
    function automatic word_t predict_key_hash(input in_t bt, input word_t seed);
        word_t       key[11];
        word_t       s4;
        word_t       d4;
        logic [15:0] pmax;
        logic [15:0] pmin;
        logic        src_gt;
        logic [63:0] ahi;
        logic [63:0] alo;
        logic [63:0] bhi;
        logic [63:0] blo;
        pmax = (bt.src_port > bt.dst_port) ? bt.src_port : bt.dst_port;
        pmin = (bt.src_port > bt.dst_port) ? bt.dst_port : bt.src_port;
        foreach (key[i])
            key[i] = '0;
        case (bt.func) inside
            FUNC_IPV4_PORTS, FUNC_IPV4_OTHER:
            begin
                s4 = bt.src_lo[31:0];
                d4 = bt.dst_lo[31:0];
                key[0] = (s4 > d4) ? s4 : d4;
                key[1] = (s4 > d4) ? d4 : s4;
                key[2] = (bt.func == FUNC_IPV4_PORTS) ? {pmin, pmax} : {FIXED_DP, FIXED_SP};
                key[3] = {8'h00, bt.tunnel_depth, 8'h00, bt.proto};
                key[4] = {bt.vlan_inner, bt.vlan_outer};
                return lookup3_hash(key, WORDS_IPV4, seed);
            end
            FUNC_IPV6:
            begin
                // Addresses compare as 128-bit numbers, word 0 most significant.
                src_gt = (bt.src_hi > bt.dst_hi) ||
                         (bt.src_hi == bt.dst_hi && bt.src_lo > bt.dst_lo);
                ahi = src_gt ? bt.src_hi : bt.dst_hi;
                alo = src_gt ? bt.src_lo : bt.dst_lo;
                bhi = src_gt ? bt.dst_hi : bt.src_hi;
                blo = src_gt ? bt.dst_lo : bt.src_lo;
                key[0] = ahi[63:32];
                key[1] = ahi[31:0];
                key[2] = alo[63:32];
                key[3] = alo[31:0];
                key[4] = bhi[63:32];
                key[5] = bhi[31:0];
                key[6] = blo[63:32];
                key[7] = blo[31:0];
                key[8] = {pmin, pmax};
                key[9] = {8'h00, bt.tunnel_depth, 8'h00, bt.proto};
                key[10] = {bt.vlan_inner, bt.vlan_outer};
                return lookup3_hash(key, WORDS_IPV6, seed);
            end
            FUNC_ZIGBEE:
            begin
                key[0] = {pmax, bt.vlan_outer};
                key[1] = {bt.vlan_inner, pmin};
                return lookup3_hash(key, WORDS_ZIGBEE, seed);
            end
            default:
                return '0;
        endcase
    endfunction

    // Compare the result beat first, then queue the prediction for a new beat, then
    // track seed writes. The seed is only written while nothing is in flight.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            seed_copy = '0;
            expected_hashes.delete();
            outstanding = 0;
            mismatches = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (expected_hashes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected key_hash beat, expected none, actual %08h",
                             $time, key_hash);
                end
                else
                begin
                    oldest = expected_hashes.pop_front();
                    if (key_hash !== oldest)
                    begin
                        mismatches++;
                        $display("%0t: key_hash mismatch, expected %08h, actual %08h",
                                 $time, oldest, key_hash);
                    end
                end
            end
            if (start && !busy)
                expected_hashes.push_back(predict_key_hash(beat, seed_copy));
            if (hash_seed_we)
                seed_copy = hash_seed_wdata;
            outstanding = expected_hashes.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// Top of the flow key hash testbench: clock, reset, directed and random header beats,
// seed changes between phases, a watchdog and the verdict.
// Depends on sfkh_pkg, symmetric_flow_key_hash and sfkh_hash_checker.
`timescale 1ns / 1ps

module tb_top
    import sfkh_pkg::*;
();

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int LATENCY        = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BEATS   = 1750;
    localparam int PHASES         = 8;
    localparam int QUIET_TAIL     = 250;
    localparam int BURST_SPAN     = 32;

    // Kind codes with no package name: everything from here up hashes to zero.
    localparam logic [2:0] FUNC_NONE      = 3'd4;
    localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_t         beat = '0;
    logic        hash_seed_we = 1'b0;
    logic [31:0] hash_seed_wdata = '0;
    logic        done;
    logic [31:0] key_hash;
    int          outstanding;
    int          mismatches;
    int          idle_cycles = 0;
    int          sent;
    bit          idling_now;

    always #(HALF_PERIOD) clk = ~clk;

    symmetric_flow_key_hash i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (beat.func),
        .src_hi          (beat.src_hi),
        .src_lo          (beat.src_lo),
        .dst_hi          (beat.dst_hi),
        .dst_lo          (beat.dst_lo),
        .src_port        (beat.src_port),
        .dst_port        (beat.dst_port),
        .proto           (beat.proto),
        .tunnel_depth    (beat.tunnel_depth),
        .vlan_outer      (beat.vlan_outer),
        .vlan_inner      (beat.vlan_inner),
        .hash_seed_we    (hash_seed_we),
        .hash_seed_wdata (hash_seed_wdata),
        .done            (done),
        .key_hash        (key_hash)
    );

    sfkh_hash_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .beat            (beat),
        .hash_seed_we    (hash_seed_we),
        .hash_seed_wdata (hash_seed_wdata),
        .done            (done),
        .key_hash        (key_hash),
        .outstanding     (outstanding),
        .mismatches      (mismatches)
    );

    // Watchdog: counts cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL symmetric_flow_key_hash");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_t make_beat(input logic [2:0] f, input logic [63:0] shi,
                                      input logic [63:0] slo, input logic [63:0] dhi,
                                      input logic [63:0] dlo, input logic [15:0] sp,
                                      input logic [15:0] dp, input logic [7:0] pr,
                                      input logic [7:0] dep, input logic [15:0] v0,
                                      input logic [15:0] v1);
        return '{func: f, src_hi: shi, src_lo: slo, dst_hi: dhi, dst_lo: dlo,
                 src_port: sp, dst_port: dp, proto: pr, tunnel_depth: dep,
                 vlan_outer: v0, vlan_inner: v1};
    endfunction

    // Mostly known kinds, with equal addresses and ports and port extremes mixed in.
    function automatic in_t random_beat();
        in_t b;
        int unsigned pick;
        b = make_beat(FUNC_IPV4_PORTS, rand64(), rand64(), rand64(), rand64(),
                      16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 28)
            b.func = FUNC_IPV4_PORTS;
        else if (pick < 46)
            b.func = FUNC_IPV4_OTHER;
        else if (pick < 74)
            b.func = FUNC_IPV6;
        else if (pick < 92)
            b.func = FUNC_ZIGBEE;
        else
            b.func = 3'($urandom_range(FUNC_NONE, FUNC_UNUSED_HI));
        case ($urandom_range(0, 9))
            0:
            begin
                b.dst_hi = b.src_hi;
                b.dst_lo = b.src_lo;
            end
            1:
                b.dst_hi = b.src_hi;
            2:
                b.dst_lo[31:0] = b.src_lo[31:0];
            default:
                ;
        endcase
        case ($urandom_range(0, 9))
            0:
                b.dst_port = b.src_port;
            1:
                b.src_port = '1;
            2:
                b.dst_port = '0;
            default:
                ;
        endcase
        return b;
    endfunction

    // Offers one beat and returns at the edge that accepts it.
    task automatic issue_beat(input in_t b);
        start <= 1'b1;
        beat <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Waits until every expected hash has come back, sampling away from the edge.
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        hash_seed_we <= 1'b1;
        hash_seed_wdata <= value;
        @(posedge clk);
        hash_seed_we <= 1'b0;
    endtask

    function automatic logic [31:0] phase_seed(input int phase);
        case (phase)
            1: return 32'hffff_ffff;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            4: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats with the reset seed: field extremes, every kind, swapped
        // directions, equal addresses and ports, ignored upper IPv4 bits.
        issue_beat(make_beat(FUNC_IPV4_PORTS, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        issue_beat(make_beat(FUNC_IPV4_PORTS, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        issue_beat(make_beat(FUNC_IPV4_PORTS, '0, 64'h0a00_0001, '0, 64'h0a00_0002,
                             16'd80, 16'd40000, 8'd6, 8'd0, 16'd10, 16'd20));
        issue_beat(make_beat(FUNC_IPV4_PORTS, '0, 64'h0a00_0002, '0, 64'h0a00_0001,
                             16'd40000, 16'd80, 8'd6, 8'd0, 16'd10, 16'd20));
        issue_beat(make_beat(FUNC_IPV4_PORTS, '0, 64'hc0a8_0101, '0, 64'hc0a8_0101,
                             16'd53, 16'd53, 8'd17, 8'd1, 16'd0, 16'd0));
        issue_beat(make_beat(FUNC_IPV4_PORTS, '0, 64'hffff_ffff_0000_0001, '0,
                             64'h0000_0000_0000_0002, 16'd1, 16'd2, 8'd1, 8'd2, 16'd3,
                             16'd4));
        issue_beat(make_beat(FUNC_IPV4_OTHER, rand64(), rand64(), rand64(), rand64(),
                             16'($urandom), 16'($urandom), 8'd1, 8'd0, 16'd5, 16'd6));
        issue_beat(make_beat(FUNC_IPV4_OTHER, '1, '1, '0, '0, '1, '0, '1, '1, '1, '1));
        issue_beat(make_beat(FUNC_IPV6, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        issue_beat(make_beat(FUNC_IPV6, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        issue_beat(make_beat(FUNC_IPV6, 64'h2001_0db8_0000_0000, 64'h5, 64'h2001_0db8_0000_0000,
                             64'h3, 16'd443, 16'd50000, 8'd6, 8'd0, 16'd1, 16'd2));
        issue_beat(make_beat(FUNC_IPV6, 64'h2001_0db8_0000_0000, 64'h3, 64'h2001_0db8_0000_0000,
                             64'h5, 16'd50000, 16'd443, 8'd6, 8'd0, 16'd1, 16'd2));
        issue_beat(make_beat(FUNC_IPV6, 64'hfe80_0000_0000_0001, '0, 64'hfe80_0000_0000_0000,
                             '1, 16'd7, 16'd9, 8'd58, 8'd3, 16'd4, 16'd5));
        issue_beat(make_beat(FUNC_IPV6, 64'h1234, 64'h5678, 64'h1234, 64'h5678, 16'd8,
                             16'd8, 8'd17, 8'd0, 16'd0, 16'd0));
        issue_beat(make_beat(FUNC_ZIGBEE, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        issue_beat(make_beat(FUNC_ZIGBEE, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        issue_beat(make_beat(FUNC_ZIGBEE, '0, '0, '0, '0, 16'h0001, 16'hfffe, '0, '0,
                             16'h1a2b, 16'd2));
        issue_beat(make_beat(FUNC_ZIGBEE, '0, '0, '0, '0, 16'hfffe, 16'h0001, '0, '0,
                             16'h1a2b, 16'd2));
        issue_beat(make_beat(FUNC_NONE, rand64(), rand64(), rand64(), rand64(),
                             '1, '1, '1, '1, '1, '1));
        issue_beat(make_beat(FUNC_SPARE_LO, '1, '1, '1, '1, '0, '0, '0, '0, '0, '0));
        issue_beat(make_beat(FUNC_SPARE_MID, rand64(), rand64(), rand64(), rand64(),
                             16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                             16'($urandom), 16'($urandom)));
        issue_beat(make_beat(FUNC_UNUSED_HI, '1, '0, '1, '0, '1, '0, '1, '0, '1, '0));

        // Random phases; the first has the reset seed, each later one writes its own
        // seed; idling comes in bursts and stops for the quiet tail of the run.
        sent = 0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                write_seed(phase_seed(phase));
            end
            for (int i = 0; i < RANDOM_BEATS / PHASES; i++)
            begin
                if (sent % BURST_SPAN == 0)
                    idling_now = ($urandom_range(0, 2) != 0);
                issue_beat(random_beat());
                sent++;
                if (idling_now && sent < RANDOM_BEATS - QUIET_TAIL &&
                    $urandom_range(0, 3) == 0)
                    pause($urandom_range(1, 14));
            end
        end

        drain();
        repeat (LATENCY + 2)
            @(posedge clk);
        if (mismatches == 0)
            $display("PASS symmetric_flow_key_hash");
        else
            $display("FAIL symmetric_flow_key_hash");
        $finish;
    end

endmodule

// File: symmetric_flow_key_hash.f
hdl/sfkh_pkg.sv
hdl/sfkh_norm.sv
hdl/sfkh_mix.sv
hdl/sfkh_final.sv
hdl/symmetric_flow_key_hash.sv
hdl/sfkh_checker.sv
tb/sfkh_hash_checker.sv
tb/tb_top.sv
